/* sv/bsl_pkg.sv */
// ----------------------------------------------------------------------------
// bsl_pkg: shared types and constants for the bounded sorted score list
// Field widths, register reset value, opcodes and the cell control word.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int TAG_BITS_DEF    = 32;

    // largest supported list depth; sizes the count and rank fields of the control word
    localparam int MAX_LIMIT = 1024;
    localparam int LIMIT_W   = $clog2(MAX_LIMIT + 1);

    localparam int SCORE_W = 32;
    localparam int CAP_W   = 7;
    localparam int RANK_W  = 6;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                      cmp_en;    // latch compare and select flags
        logic                      upd_en;    // apply the insert shift
        logic signed [SCORE_W-1:0] new_score;
        logic [LIMIT_W-1:0]        held_cnt;  // entries currently held
        logic [LIMIT_W-1:0]        sel_idx;   // rank chosen by a read
    } cell_ctrl_t;

endpackage

/* sv/bsl_cell.sv */
// ----------------------------------------------------------------------------
// bsl_cell: one slot of the sorted list
// Holds a score and tag, flags whether it outranks the incoming score, and
// on insert keeps, loads the new entry, or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module bsl_cell #(
    parameter int IDX      = 0,
    parameter int TAG_BITS = bsl_pkg::TAG_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bsl_pkg::cell_ctrl_t                ctrl,
    input  logic [TAG_BITS-1:0]                new_tag,
    input  logic                               left_gt,
    input  logic signed [bsl_pkg::SCORE_W-1:0] left_score,
    input  logic [TAG_BITS-1:0]                left_tag,
    output logic                               gt,
    output logic signed [bsl_pkg::SCORE_W-1:0] score,
    output logic [TAG_BITS-1:0]                tag,
    output logic signed [bsl_pkg::SCORE_W-1:0] rd_score,
    output logic [TAG_BITS-1:0]                rd_tag
);
    import bsl_pkg::*;

    localparam logic [LIMIT_W-1:0] MY_IDX = LIMIT_W'(IDX);

    logic                      gt_reg;
    logic                      hit_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [TAG_BITS-1:0]       tag_reg;
    logic                      held;

    assign held = MY_IDX < ctrl.held_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            gt_reg  <= held && (score_reg > ctrl.new_score);
            hit_reg <= MY_IDX == ctrl.sel_idx;
        end
    end

    // slots ahead of the insert point keep; the insert point loads; the rest shift
    always_ff @(posedge clk)
    begin
        if (ctrl.upd_en && !gt_reg)
        begin
            if (left_gt)
            begin
                score_reg <= ctrl.new_score;
                tag_reg   <= new_tag;
            end
            else
            begin
                score_reg <= left_score;
                tag_reg   <= left_tag;
            end
        end
    end

    assign gt       = gt_reg;
    assign score    = score_reg;
    assign tag      = tag_reg;
    assign rd_score = hit_reg ? score_reg : '0;
    assign rd_tag   = hit_reg ? tag_reg : '0;

endmodule

/* sv/bounded_sorted_score_list.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_score_list: top-k descending score list
// Chain of cells, one per entry, kept sorted by insertion; reads by rank.
// ----------------------------------------------------------------------------
// Flow: an accepted input word passes the compare in every cell, the shift or
//   gather, and the result register before its result word is offered.
// The controller walks accept, compare, apply and result steps for one word at
//   a time; a result word still stalled on the output holds the next word in
//   the result step.
// Reset: rst_n clears the entry count to zero and capacity to 64; slot
//   contents are not cleared, since only held slots are ever read.
// ----------------------------------------------------------------------------
module bounded_sorted_score_list #(
    parameter int MAX_ENTRIES = bsl_pkg::MAX_ENTRIES_DEF,
    parameter int TAG_BITS    = bsl_pkg::TAG_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel (capacity)
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsl_pkg::CAP_W-1:0]          cfg_data,
    // input words
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic signed [bsl_pkg::SCORE_W-1:0] score,
    input  logic [TAG_BITS-1:0]                tag,
    input  logic [bsl_pkg::IDX_W-1:0]          read_index,
    // result words
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               accepted,
    output logic [bsl_pkg::RANK_W-1:0]         rank,
    output logic [bsl_pkg::CNT_W-1:0]          entry_count,
    output logic                               read_valid,
    output logic signed [bsl_pkg::SCORE_W-1:0] read_score,
    output logic [TAG_BITS-1:0]                read_tag
);
    import bsl_pkg::*;

    localparam int CW  = $clog2(MAX_ENTRIES + 1);   // count width
    localparam int GRP = 8;                          // cells per gather group
    localparam int NG  = (MAX_ENTRIES + GRP - 1) / GRP;
    localparam logic [LIMIT_W-1:0] MAX_L = LIMIT_W'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_APPLY = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CAP_W-1:0]     capacity_reg;
    logic [CW-1:0]        count_reg;

    // latched input word
    logic                 kind_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [IDX_W-1:0]     idx_reg;

    // per-item results waiting for the output register
    logic                 acc_pend_reg;
    logic [RANK_W-1:0]    rank_pend_reg;
    logic [RANK_W-1:0]    rd_rank_reg;

    // gathered read data, one word per group
    logic signed [SCORE_W-1:0] grp_score_reg [NG];
    logic [TAG_BITS-1:0]       grp_tag_reg   [NG];

    // output register
    logic                 out_valid_reg;
    logic                 accepted_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic [CNT_W-1:0]     entry_count_reg;
    logic                 read_valid_reg;
    logic signed [SCORE_W-1:0] read_score_reg;
    logic [TAG_BITS-1:0]  read_tag_reg;

    cell_ctrl_t                ctrl;
    logic [MAX_ENTRIES-1:0]    gt_vec;
    logic signed [SCORE_W-1:0] c_score    [MAX_ENTRIES];
    logic [TAG_BITS-1:0]       c_tag      [MAX_ENTRIES];
    logic signed [SCORE_W-1:0] c_rd_score [MAX_ENTRIES];
    logic [TAG_BITS-1:0]       c_rd_tag   [MAX_ENTRIES];

    logic [LIMIT_W-1:0] count_l;
    logic [LIMIT_W-1:0] cap_raw;
    logic [LIMIT_W-1:0] eff_cap;
    logic [LIMIT_W-1:0] sel_idx;
    logic [LIMIT_W-1:0] ins_pos;
    logic               full;
    logic               drop;
    logic               do_insert;
    logic               out_free;
    logic signed [SCORE_W-1:0] fin_score;
    logic [TAG_BITS-1:0]       fin_tag;

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == S_IDLE;
    assign out_free  = !out_valid_reg || out_ready;

    assign count_l = LIMIT_W'(count_reg);
    assign cap_raw = LIMIT_W'(capacity_reg);

    // capacity of zero acts as one, above the depth acts as the depth
    always_comb
    begin
        if (cap_raw == '0)
            eff_cap = LIMIT_W'(1);
        else if (cap_raw > MAX_L)
            eff_cap = MAX_L;
        else
            eff_cap = cap_raw;
    end

    assign full = count_l >= eff_cap;

    // a read past the count lands on the last held entry
    always_comb
    begin
        if (LIMIT_W'(idx_reg) >= count_l)
            sel_idx = count_l - LIMIT_W'(1);
        else
            sel_idx = LIMIT_W'(idx_reg);
    end

    // insert point: the greater-than flags form a run of ones from rank 0,
    // so the position is the first zero (or the depth when all are set)
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (((i == 0) ? 1'b1 : gt_vec[(i == 0) ? 0 : i - 1]) && !gt_vec[i])
                ins_pos = ins_pos | LIMIT_W'(i);
        end
        if (gt_vec[MAX_ENTRIES-1])
            ins_pos = MAX_L;
    end

    // full list and newcomer below every held score: nothing changes
    assign drop      = full && (ins_pos >= count_l);
    assign do_insert = (state_reg == S_APPLY) && (kind_reg == KIND_INSERT) && !drop;

    always_comb
    begin
        ctrl.cmp_en    = state_reg == S_CMP;
        ctrl.upd_en    = do_insert;
        ctrl.new_score = score_reg;
        ctrl.held_cnt  = count_l;
        ctrl.sel_idx   = sel_idx;
    end

    // the cell chain
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic                      l_gt;
        logic signed [SCORE_W-1:0] l_score;
        logic [TAG_BITS-1:0]       l_tag;

        if (i == 0)
        begin : g_head
            assign l_gt    = 1'b1;
            assign l_score = score_reg;
            assign l_tag   = tag_reg;
        end
        else
        begin : g_body
            assign l_gt    = gt_vec[i-1];
            assign l_score = c_score[i-1];
            assign l_tag   = c_tag[i-1];
        end

        bsl_cell #(
            .IDX      (i),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_tag    (tag_reg),
            .left_gt    (l_gt),
            .left_score (l_score),
            .left_tag   (l_tag),
            .gt         (gt_vec[i]),
            .score      (c_score[i]),
            .tag        (c_tag[i]),
            .rd_score   (c_rd_score[i]),
            .rd_tag     (c_rd_tag[i])
        );
    end

    // first level of the read gather: OR of one group of masked cell outputs
    function automatic logic signed [SCORE_W-1:0] group_or_score(input int g);
        logic signed [SCORE_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < GRP; k++)
        begin
            if (g * GRP + k < MAX_ENTRIES)
                acc = acc | c_rd_score[g * GRP + k];
        end
        return acc;
    endfunction

    function automatic logic [TAG_BITS-1:0] group_or_tag(input int g);
        logic [TAG_BITS-1:0] acc;
        acc = '0;
        for (int k = 0; k < GRP; k++)
        begin
            if (g * GRP + k < MAX_ENTRIES)
                acc = acc | c_rd_tag[g * GRP + k];
        end
        return acc;
    endfunction

    // second level of the read gather: at most one cell has its hit flag set
    always_comb
    begin
        fin_score = '0;
        fin_tag   = '0;
        for (int g = 0; g < NG; g++)
        begin
            fin_score = fin_score | grp_score_reg[g];
            fin_tag   = fin_tag | grp_tag_reg[g];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CMP;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                capacity_reg <= cfg_data;
            if (do_insert && !full)
                count_reg <= count_reg + CW'(1);
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            kind_reg  <= kind;
            score_reg <= score;
            tag_reg   <= tag;
            idx_reg   <= read_index;
        end

        if (state_reg == S_CMP)
            rd_rank_reg <= (count_l == '0) ? '0 : sel_idx[RANK_W-1:0];

        if (state_reg == S_APPLY)
        begin
            acc_pend_reg  <= (kind_reg == KIND_INSERT) && !drop;
            rank_pend_reg <= drop ? '0 : ins_pos[RANK_W-1:0];
            for (int g = 0; g < NG; g++)
            begin
                grp_score_reg[g] <= group_or_score(g);
                grp_tag_reg[g]   <= group_or_tag(g);
            end
        end

        if (state_reg == S_FIN && out_free)
        begin
            entry_count_reg <= CNT_W'(count_reg);
            if (kind_reg == KIND_INSERT)
            begin
                accepted_reg   <= acc_pend_reg;
                rank_reg       <= rank_pend_reg;
                read_valid_reg <= 1'b0;
                read_score_reg <= '0;
                read_tag_reg   <= '0;
            end
            else
            begin
                accepted_reg   <= 1'b0;
                rank_reg       <= rd_rank_reg;
                read_valid_reg <= count_reg != '0;
                read_score_reg <= fin_score;
                read_tag_reg   <= fin_tag;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign rank        = rank_reg;
    assign entry_count = entry_count_reg;
    assign read_valid  = read_valid_reg;
    assign read_score  = read_score_reg;
    assign read_tag    = read_tag_reg;

endmodule

/* sv/bsl_checker.sv */
// ----------------------------------------------------------------------------
// bsl_checker: port-level checks for the bounded sorted score list
// Watches the result channel and bound to every instance of the top level.
// ----------------------------------------------------------------------------
module bsl_checker #(
    parameter int TAG_BITS = bsl_pkg::TAG_BITS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               accepted,
    input logic [bsl_pkg::RANK_W-1:0]         rank,
    input logic [bsl_pkg::CNT_W-1:0]          entry_count,
    input logic                               read_valid,
    input logic signed [bsl_pkg::SCORE_W-1:0] read_score,
    input logic [TAG_BITS-1:0]                read_tag
);
    import bsl_pkg::*;

    // a stalled result word holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(read_score)
            && $stable(read_tag) && $stable(accepted) && $stable(entry_count))
        else $error("result word changed while stalled");

    // a word is either a stored insert or a read, never both
    a_acc_vs_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(accepted && read_valid))
        else $error("insert and read result flagged together");

    // a stored entry or a returned read implies a non-empty list
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (accepted || read_valid) |-> entry_count != '0)
        else $error("entry reported with empty list");

    // on a stored entry or a returned read, rank falls inside the held entries
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (accepted || read_valid) && entry_count <= CNT_W'(64)
            |-> CNT_W'(rank) < entry_count)
        else $error("rank beyond entry count");

endmodule

bind bounded_sorted_score_list bsl_checker #(
    .TAG_BITS (TAG_BITS)
) u_bsl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .rank        (rank),
    .entry_count (entry_count),
    .read_valid  (read_valid),
    .read_score  (read_score),
    .read_tag    (read_tag)
);

/* tb/sv/bounded_sorted_score_list_checker.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_score_list_checker: result checker for the score list
// Keeps its own copy of the sorted list and the capacity register. On every
// accepted input word it computes the result word due and queues it. Every
// result word taken from the block is compared field by field with the
// oldest one queued.
// ----------------------------------------------------------------------------
module bounded_sorted_score_list_checker #(
    parameter int DEPTH = bsl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bsl_pkg::CAP_W-1:0]          cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               kind,
    input  logic signed [bsl_pkg::SCORE_W-1:0] score,
    input  logic [31:0]                        tag,
    input  logic [bsl_pkg::IDX_W-1:0]          read_index,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               accepted,
    input  logic [bsl_pkg::RANK_W-1:0]         rank,
    input  logic [bsl_pkg::CNT_W-1:0]          entry_count,
    input  logic                               read_valid,
    input  logic signed [bsl_pkg::SCORE_W-1:0] read_score,
    input  logic [31:0]                        read_tag,
    output int                                 mismatches,
    output int                                 due_count
);
    import bsl_pkg::*;

    typedef struct packed {
        logic                      accepted;
        logic [RANK_W-1:0]         rank;
        logic [CNT_W-1:0]          count;
        logic                      read_valid;
        logic signed [SCORE_W-1:0] read_score;
        logic [31:0]               read_tag;
    } list_word_t;

    logic signed [SCORE_W-1:0] slot_score [DEPTH];
    logic [31:0]               slot_tag [DEPTH];
    int                        held;
    logic [CAP_W-1:0]          cap_reg;
    list_word_t                due_words [$];

    initial mismatches = 0;
    initial due_count = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // one insert or read applied to the list copy; returns the word it causes
    function automatic list_word_t apply_list_item(input logic k,
                                                   input logic signed [SCORE_W-1:0] s,
                                                   input logic [31:0] t,
                                                   input logic [IDX_W-1:0] idx);
        list_word_t w;
        int         limit;
        int         pos;
        int         last;
        bit         full;
        w = '0;
        limit = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        if (k == KIND_INSERT)
        begin
            full = held >= limit;
            pos = 0;
            while (pos < held && slot_score[pos] > s)
                pos++;
            // full list and every held score higher: dropped
            if (!(full && pos >= held))
            begin
                last = full ? held - 1 : held;
                for (int i = last; i > pos; i--)
                begin
                    slot_score[i] = slot_score[i-1];
                    slot_tag[i]   = slot_tag[i-1];
                end
                slot_score[pos] = s;
                slot_tag[pos]   = t;
                if (!full)
                    held++;
                w.accepted = 1'b1;
                w.rank     = RANK_W'(pos);
            end
        end
        else if (held > 0)
        begin
            pos = (int'(idx) >= held) ? held - 1 : int'(idx);
            w.read_valid = 1'b1;
            w.rank       = RANK_W'(pos);
            w.read_score = slot_score[pos];
            w.read_tag   = slot_tag[pos];
        end
        w.count = CNT_W'(held);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_word_t want;
        if (!rst_n)
        begin
            held    = 0;
            cap_reg = CAP_RESET;
            due_words.delete();
            due_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                    flag_mismatch("result word with none due", 32'(rank), 32'(0));
                else
                begin
                    want = due_words.pop_front();
                    if (accepted !== want.accepted)
                        flag_mismatch("accepted", 32'(accepted), 32'(want.accepted));
                    if (rank !== want.rank)
                        flag_mismatch("rank", 32'(rank), 32'(want.rank));
                    if (entry_count !== want.count)
                        flag_mismatch("entry_count", 32'(entry_count), 32'(want.count));
                    if (read_valid !== want.read_valid)
                        flag_mismatch("read_valid", 32'(read_valid), 32'(want.read_valid));
                    if (read_score !== want.read_score)
                        flag_mismatch("read_score", read_score, want.read_score);
                    if (read_tag !== want.read_tag)
                        flag_mismatch("read_tag", read_tag, want.read_tag);
                end
            end
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if (in_valid && in_ready)
                due_words = {due_words, apply_list_item(kind, score, tag, read_index)};
            due_count <= due_words.size();
        end
    end

endmodule

/* tb/sv/bounded_sorted_score_list_test.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_score_list_test: top level of the score list testbench
// Drives capacity writes and insert/read words into the block, stalls the
// result side at random, and leaves prediction and comparison to the
// checker. A directed part walks the corner cases, then random phases run
// the list through a range of capacities, small ones first since the list
// never shrinks.
// ----------------------------------------------------------------------------
module bounded_sorted_score_list_test;
    import bsl_pkg::*;

    // slowest item: drawn idle gap, pass through the block and drawn stall,
    // serialized; about 1600 items plus config pauses stays far below this
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 158;
    localparam int PHASE_COUNT  = 10;
    localparam int SETTLE_TICKS = 8;    // longer than the block's latency

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CAP_W-1:0]          cfg_data   = '0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic                      kind       = KIND_INSERT;
    logic signed [SCORE_W-1:0] score      = '0;
    logic [31:0]               tag        = '0;
    logic [IDX_W-1:0]          read_index = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic                      accepted;
    logic [RANK_W-1:0]         rank;
    logic [CNT_W-1:0]          entry_count;
    logic                      read_valid;
    logic signed [SCORE_W-1:0] read_score;
    logic [31:0]               read_tag;

    int mismatches;
    int due_count;
    int cycle_count = 0;
    int sink_wait   = 0;
    bit no_gaps     = 1'b0;   // phases with back-to-back traffic on both sides

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bounded_sorted_score_list dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .score       (score),
        .tag         (tag),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .rank        (rank),
        .entry_count (entry_count),
        .read_valid  (read_valid),
        .read_score  (read_score),
        .read_tag    (read_tag)
    );

    bounded_sorted_score_list_checker score_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .score       (score),
        .tag         (tag),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .rank        (rank),
        .entry_count (entry_count),
        .read_valid  (read_valid),
        .read_score  (read_score),
        .read_tag    (read_tag),
        .mismatches  (mismatches),
        .due_count   (due_count)
    );

    // idle or stall cycles for one word; zero throughout a no-gap phase
    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Result side: after each result word taken, hold ready low for a drawn
    // number of cycles. Ready may sit high before a word shows up.
    always @(posedge clk or negedge rst_n)
    begin : sink
        int w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            w = draw_gap();
            sink_wait <= w;
            out_ready <= (w == 0);
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            out_ready <= (sink_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog. Counts every cycle from time zero, reset included.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bounded_sorted_score_list_test NOT OK");
            $finish;
        end
    end

    // One input word. Valid stays high from one word straight into the next
    // when no gap is drawn; it drops only for a real gap or a drain.
    task automatic send_word(input logic k, input logic signed [SCORE_W-1:0] s,
                             input logic [31:0] t, input logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        score      <= s;
        tag        <= t;
        read_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic post_insert(input logic signed [SCORE_W-1:0] s, input logic [31:0] t);
        send_word(KIND_INSERT, s, t, IDX_W'($urandom()));
    endtask

    // score and tag lines carry noise on a read; the block must ignore them
    task automatic post_read(input logic [IDX_W-1:0] idx);
        send_word(KIND_READ, $urandom(), $urandom(), idx);
    endtask

    // Drop valid, wait until every due word is back, then let the block settle.
    // The first edge lets the checker's count catch up with the last push.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_count != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // capacity write, only issued with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random word. Inserts lean on a narrow score band so that ties are
    // common; the rest spans the full range, the extremes and Q16.16 whole
    // numbers. Reads favor low ranks but also cover every index.
    task automatic random_item();
        int                        pick;
        int                        v;
        logic signed [SCORE_W-1:0] s;
        logic [31:0]               t;
        if ($urandom_range(0, 99) < 55)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                v = $urandom_range(0, 16);
                s = v - 8;
            end
            else if (pick < 7)
                s = $urandom();
            else if (pick == 7)
            begin
                case ($urandom_range(0, 3))
                    0: s = 32'sh7FFF_FFFF;
                    1: s = 32'sh8000_0000;
                    2: s = 32'sh0000_0000;
                    default: s = 32'shFFFF_FFFF;
                endcase
            end
            else
            begin
                // Q16.16 whole numbers in a modest band
                v = $urandom_range(0, 400);
                s = (v - 200) <<< 16;
            end
            t = ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : 32'($urandom());
            post_insert(s, t);
        end
        else if ($urandom_range(0, 1) == 0)
            post_read(IDX_W'($urandom_range(0, 7)));
        else
            post_read(IDX_W'($urandom()));
    endtask

    initial
    begin : stimulus
        int phase_caps [PHASE_COUNT];
        phase_caps = '{1, 0, 2, 5, 17, 40, 64, 127, 7, 0};
        phase_caps[5] = $urandom_range(18, 63);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        write_capacity(CAP_W'(4));
        // empty list: read reports not valid, whatever the index
        post_read(IDX_W'(0));
        post_read(IDX_W'(63));
        post_insert(32'sh0000_0000, 32'h0000_0000);
        post_insert(32'sh7FFF_FFFF, 32'hFFFF_FFFF);          // goes to the head
        post_insert(32'sh8000_0000, 32'h5555_5555);          // goes to the tail
        post_insert(32'sh0000_0000, 32'hAAAA_AAAA);          // tie: ahead of the old zero
        // list is now full; a tie with the lowest still gets in and evicts it
        post_insert(32'sh8000_0000, 32'h0000_0001);
        post_insert(32'sh0000_0005, 32'h0000_0005);          // middle, evicts the tail
        post_insert(32'shFFFF_FFFF, 32'h0BAD_0001);          // below all: dropped
        post_read(IDX_W'(0));
        post_read(IDX_W'(2));
        post_read(IDX_W'(3));
        post_read(IDX_W'(63));                               // past the count: last entry
        drain();
        // capacity under the count: count stays, inserts only swap out the tail
        write_capacity(CAP_W'(2));
        post_insert(32'sh0000_0001, 32'h0000_0011);
        post_insert(32'shFFFF_FF9C, 32'h0000_0012);          // dropped
        post_read(IDX_W'(63));
        drain();
        // zero acts as one
        write_capacity(CAP_W'(0));
        post_insert(32'sh0000_0007, 32'h0000_0021);
        post_read(IDX_W'(1));
        drain();
        // above the depth acts as the depth: the list grows again
        write_capacity(CAP_W'(127));
        post_insert(32'sh0000_0003, 32'h0000_0031);
        post_read(IDX_W'(4));
        drain();

        // ---- random phases ----
        // The list never shrinks, so small capacities come first while it is
        // still short; the late small ones then run with the count far above.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            no_gaps = (p % 3 == 2);
            write_capacity(CAP_W'(phase_caps[p]));
            repeat (PHASE_ITEMS) random_item();
            drain();
        end

        no_gaps = 1'b0;
        if (mismatches == 0)
            $display("bounded_sorted_score_list_test OK");
        else
            $display("bounded_sorted_score_list_test NOT OK");
        $finish;
    end

endmodule
